FILE: rtl/f2sd_pkg.sv
package f2sd_pkg;

  // 2^96 as float bits; larger positive magnitudes are rejected
  localparam logic [30:0] HUGE_BITS = 31'h6F80_0000;
  // first float above 1e-28; smaller positive magnitudes are rejected
  localparam logic [30:0] TINY_BITS = 31'h10FD_87B6;

  localparam int SIG_W   = 24;
  localparam int P10_W   = 20;
  localparam int PROD_W  = SIG_W + P10_W;
  localparam int SHIFT_W = 105;
  localparam int MANT_W  = 96;

  // sig * 2^(exp2-23) compared against these gives |a|*10 > 2^96 and |a| > 10^k
  localparam logic [SHIFT_W-1:0] SCALE0_LIM = (105'd1 << 72) / 105'd5;
  localparam logic [SHIFT_W-1:0] POW10_LIM [0:4] = '{
    105'd11920928955078125,
    105'd59604644775390625 << 1,
    105'd298023223876953125 << 2,
    105'd1490116119384765625 << 3,
    105'd7450580596923828125 << 4
  };

  typedef struct packed {
    logic [SIG_W-1:0]  sig;
    logic signed [8:0] exp2;
    logic [2:0]        scale;
    logic              negative;
    logic              status;
  } job_t;

  typedef struct packed {
    logic [PROD_W-1:0] prod;
    logic signed [8:0] exp2;
    logic [2:0]        scale;
    logic              negative;
    logic              status;
  } prod_t;

  function automatic logic [P10_W-1:0] pow10(input logic [2:0] s);
    logic [P10_W-1:0] r;
    case (s)
      3'd0:    r = 20'd1;
      3'd1:    r = 20'd10;
      3'd2:    r = 20'd100;
      3'd3:    r = 20'd1000;
      3'd4:    r = 20'd10000;
      3'd5:    r = 20'd100000;
      3'd6:    r = 20'd1000000;
      default: r = 20'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/f2sd_if.sv
interface f2sd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] float_bits;

  modport source (output valid, output float_bits, input ready);
  modport sink   (input valid, input float_bits, output ready);
endinterface

interface f2sd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] mantissa_low;
  logic [31:0] mantissa_high;
  logic [2:0]  scale;
  logic        negative;
  logic        status;

  modport source (output valid, output mantissa_low, output mantissa_high,
                  output scale, output negative, output status, input ready);
  modport sink   (input valid, input mantissa_low, input mantissa_high,
                  input scale, input negative, input status, output ready);
endinterface

FILE: rtl/f2sd_front.sv
module f2sd_front
  import f2sd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  f2sd_in_if.sink   in_chan,
  output logic      job_valid,
  input  logic      job_ready,
  output job_t      job
);

  logic                    sgn;
  logic [7:0]              ef;
  logic [22:0]             frac;
  logic [30:0]             mag;
  logic [SIG_W-1:0]        sig;
  logic signed [8:0]       exp2;
  logic signed [8:0]       t0;
  logic [SHIFT_W-1:0]      shifted;
  logic [4:0]              above;
  logic                    to_int;
  logic [2:0]              scale;
  logic                    in_ready;
  job_t                    job_nxt;
  job_t                    job_r;
  logic                    job_valid_r;

  always_comb begin
    sgn   = in_chan.float_bits[31];
    ef    = in_chan.float_bits[30:23];
    frac  = in_chan.float_bits[22:0];
    mag   = in_chan.float_bits[30:0];
    sig   = (ef == 8'd0) ? {1'b0, frac} : {1'b1, frac};
    exp2  = (ef == 8'd0) ? -9'sd149 : ($signed({1'b0, ef}) - 9'sd150);
    t0    = exp2 - 9'sd23;
    shifted = t0[8] ? '0 : ({{(SHIFT_W-SIG_W){1'b0}}, sig} << t0[6:0]);
    for (int i = 0; i < 5; i++) begin
      above[i] = shifted > POW10_LIM[i];
    end
    to_int = shifted > SCALE0_LIM;
    scale  = to_int ? 3'd0 : (3'd6 - 3'($countones(above)));
  end

  always_comb begin
    job_nxt = '0;
    if (ef == 8'hFF) begin
      if (frac != 23'd0) begin
        job_nxt.scale = 3'd6;
      end else begin
        job_nxt.status = 1'b1;
      end
    end else if (sig == '0) begin
      job_nxt.scale = 3'd6;
    end else if (!sgn && (mag > HUGE_BITS || mag < TINY_BITS)) begin
      job_nxt.status = 1'b1;
    end else begin
      job_nxt.sig      = sig;
      job_nxt.exp2     = exp2;
      job_nxt.scale    = scale;
      job_nxt.negative = sgn;
    end
  end

  assign in_ready      = !job_valid_r || job_ready;
  assign in_chan.ready = in_ready;
  assign job_valid     = job_valid_r;
  assign job           = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
    end else if (in_ready) begin
      job_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_ready) begin
      job_r <= job_nxt;
    end
  end

endmodule

FILE: rtl/f2sd_queue.sv
module f2sd_queue
  import f2sd_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count_r != FULL;
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/f2sd_back.sv
module f2sd_back
  import f2sd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  output logic        job_ready,
  input  job_t        job,
  f2sd_out_if.source  out_chan
);

  prod_t              prod_nxt;
  prod_t              prod_r;
  logic               prod_valid_r;
  logic               a_ready;
  logic               b_ready;
  logic signed [8:0]  neg_exp;
  logic [PROD_W:0]    pe;
  logic [PROD_W:0]    rounded;
  logic [MANT_W-1:0]  mant_nxt;
  logic [MANT_W-1:0]  mant_r;
  logic [2:0]         scale_r;
  logic               negative_r;
  logic               status_r;
  logic               out_valid_r;

  assign b_ready   = !out_valid_r || out_chan.ready;
  assign a_ready   = !prod_valid_r || b_ready;
  assign job_ready = a_ready;

  always_comb begin
    prod_nxt.prod     = {{P10_W{1'b0}}, job.sig} * {{SIG_W{1'b0}}, pow10(job.scale)};
    prod_nxt.exp2     = job.exp2;
    prod_nxt.scale    = job.scale;
    prod_nxt.negative = job.negative;
    prod_nxt.status   = job.status;
  end

  // left shift for non-negative exponent, otherwise shift right and round half up
  always_comb begin
    neg_exp = -prod_r.exp2;
    pe      = {prod_r.prod, 1'b0} >> neg_exp[7:0];
    rounded = {1'b0, pe[PROD_W:1]} + {{PROD_W{1'b0}}, pe[0]};
    if (!prod_r.exp2[8]) begin
      mant_nxt = {{(MANT_W-PROD_W){1'b0}}, prod_r.prod} << prod_r.exp2[6:0];
    end else begin
      mant_nxt = {{(MANT_W-PROD_W-1){1'b0}}, rounded};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (a_ready) begin
        prod_valid_r <= job_valid;
      end
      if (b_ready) begin
        out_valid_r <= prod_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && a_ready) begin
      prod_r <= prod_nxt;
    end
    if (prod_valid_r && b_ready) begin
      mant_r     <= mant_nxt;
      scale_r    <= prod_r.scale;
      negative_r <= prod_r.negative;
      status_r   <= prod_r.status;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.mantissa_low  = mant_r[63:0];
  assign out_chan.mantissa_high = mant_r[95:64];
  assign out_chan.scale         = scale_r;
  assign out_chan.negative      = negative_r;
  assign out_chan.status        = status_r;

endmodule

FILE: rtl/float_to_scaled_decimal.sv
// Converts IEEE single-precision bits to a sign, a decimal scale (0..6) and a
// 96-bit mantissa rounded half away from zero. Positive values below 1e-28 or
// above 2^96 and both infinities come back with status 1 and all else zero;
// NaN and zero give mantissa 0 with scale 6. One transaction is taken per
// clock when the result side keeps up; a result passes through a classify
// register, the queue, a product register (24x20 multiply) and the output
// register holding the shift and rounding. The queue of QUEUE_DEPTH entries
// (at least 2) lets the classifier and the multiply/shift back end stall
// independently.
module float_to_scaled_decimal
  import f2sd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  f2sd_in_if.sink    in_chan,
  f2sd_out_if.source out_chan
);

  logic front_valid;
  logic front_ready;
  job_t front_job;
  logic back_valid;
  logic back_ready;
  job_t back_job;

  f2sd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .job_valid (front_valid),
    .job_ready (front_ready),
    .job       (front_job)
  );

  f2sd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_job),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_data   (back_job)
  );

  f2sd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (back_valid),
    .job_ready (back_ready),
    .job       (back_job),
    .out_chan  (out_chan)
  );

endmodule
